// ===== hw/rtl/tla_pkg.sv =====
// Shared types, constants and helpers for the toroidal life automaton.
// No dependencies; imported by the core and the row evaluator.
package tla_pkg;

    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CFG_W    = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int REG_IW   = APB_AW - 2;

    typedef logic [MAX_COLS-1:0] t_row;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_ADV   = 2'd2;

    localparam logic [REG_IW-1:0] REG_ROWS = REG_IW'(0);
    localparam logic [REG_IW-1:0] REG_COLS = REG_IW'(1);

    // zero acts as one, oversize clamps to the limit
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] s;
        s = v;
        if (v == '0) begin
            s = CFG_W'(1);
        end else if (v > lim) begin
            s = lim;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/tla_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/tla_row_eval.sv =====
// Next-generation evaluator for one row: one lane per column, wrapping at the
// active column count. Depends on tla_pkg.
module tla_row_eval (
    input  tla_pkg::t_row             i_up,
    input  tla_pkg::t_row             i_cur,
    input  tla_pkg::t_row             i_down,
    input  logic [tla_pkg::CFG_W-1:0] i_cols,
    output tla_pkg::t_row             o_next
);
    import tla_pkg::*;

    logic [CFG_W-1:0] cols_m1;
    logic             wl_up;
    logic             wl_cur;
    logic             wl_down;

    assign cols_m1 = i_cols - CFG_W'(1);
    assign wl_up   = i_up[cols_m1[COL_W-1:0]];
    assign wl_cur  = i_cur[cols_m1[COL_W-1:0]];
    assign wl_down = i_down[cols_m1[COL_W-1:0]];

    for (genvar gj = 0; gj < MAX_COLS; gj++) begin : g_lane
        logic       l_up, l_cur, l_down;
        logic       r_up_b, r_cur_b, r_down_b;
        logic [3:0] cnt;
        logic       live;

        if (gj == 0) begin : g_left_wrap
            assign l_up   = wl_up;
            assign l_cur  = wl_cur;
            assign l_down = wl_down;
        end else begin : g_left
            assign l_up   = i_up[gj-1];
            assign l_cur  = i_cur[gj-1];
            assign l_down = i_down[gj-1];
        end

        if (gj == MAX_COLS - 1) begin : g_right_edge
            assign r_up_b   = i_up[0];
            assign r_cur_b  = i_cur[0];
            assign r_down_b = i_down[0];
        end else begin : g_right
            logic wrap;
            assign wrap     = (i_cols == CFG_W'(gj + 1));
            assign r_up_b   = wrap ? i_up[0]   : i_up[gj+1];
            assign r_cur_b  = wrap ? i_cur[0]  : i_cur[gj+1];
            assign r_down_b = wrap ? i_down[0] : i_down[gj+1];
        end

        assign cnt = {3'b0, l_up} + {3'b0, i_up[gj]} + {3'b0, r_up_b}
                   + {3'b0, l_down} + {3'b0, i_down[gj]} + {3'b0, r_down_b}
                   + {3'b0, l_cur} + {3'b0, r_cur_b};

        assign live = i_cur[gj] ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);

        // columns past the active width keep their contents
        assign o_next[gj] = (CFG_W'(gj) < i_cols) ? live : i_cur[gj];
    end
endmodule

// ===== hw/rtl/toroidal_life_automaton_core.sv =====
// Channel     | Signals                                      | Beat
// ------------+----------------------------------------------+--------------------------
// item in     | i_in_valid/o_in_ready, mode row col value    | one read, write or advance
// result out  | o_out_valid/i_out_ready, cell_res out_of_range | one per item
// config      | APB psel penable pwrite paddr pwdata prdata  | row_count @0, col_count @4
//
// Top level: toroidal life grid held in a row-wide RAM (one row per entry).
// Depends on tla_pkg, tla_ram, tla_row_eval.
// From accept to result: out of range or unused mode go straight to the result load;
// read/write do a RAM read then modify/write; advance primes the row window (up row,
// then current row), sweeps one row per cycle via the RAM ports, then loads the result.
// One item is in work at a time; the next beat is taken once the result is
// in the output register. Reset marks every row invalid (reads as dead), no sweep.
// A stalled output holds its beat; a new result waits until it is taken.
module toroidal_life_automaton_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [tla_pkg::ROW_W-1:0]   i_row,
    input  logic [tla_pkg::COL_W-1:0]   i_col,
    input  logic                        i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_cell_res,
    output logic                        o_out_of_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tla_pkg::APB_AW-1:0]  paddr,
    input  logic [tla_pkg::APB_DW-1:0]  pwdata,
    output logic [tla_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tla_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ADV_UP,
        ST_ADV_CUR,
        ST_ADV_ROW,
        ST_FIN
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_row_cnt;
    logic [CFG_W-1:0]   r_col_cnt;
    logic [MAX_ROWS-1:0] r_row_vld;
    logic               r_rd_vld;
    logic [1:0]         r_mode;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_value;
    logic               r_res_cell;
    logic               r_res_oor;
    logic               r_out_valid;
    logic               r_out_cell;
    logic               r_out_oor;
    t_row               r_up;
    t_row               r_cur;
    t_row               r_first;
    logic [CFG_W-1:0]   r_idx;

    logic [CFG_W-1:0]   rows_eff;
    logic [CFG_W-1:0]   cols_eff;
    logic [CFG_W-1:0]   rows_m1;
    logic [CFG_W-1:0]   idx_p1;
    logic [CFG_W-1:0]   idx_p2;
    logic               last_row;
    logic               accept;
    logic               in_range;
    logic               cfg_wr;
    logic               rd_en;
    logic [ROW_W-1:0]   rd_addr;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_addr;
    t_row               wr_data;
    t_row               ram_rdata;
    t_row               rd_mask;
    t_row               down;
    t_row               next_row;
    t_row               cell_wr;

    assign rows_eff = eff_size(r_row_cnt, CFG_W'(MAX_ROWS));
    assign cols_eff = eff_size(r_col_cnt, CFG_W'(MAX_COLS));
    assign rows_m1  = rows_eff - CFG_W'(1);
    assign idx_p1   = r_idx + CFG_W'(1);
    assign idx_p2   = r_idx + CFG_W'(2);
    assign last_row = (idx_p1 == rows_eff);

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (CFG_W'(i_row) < rows_eff) && (CFG_W'(i_col) < cols_eff);
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign rd_mask = r_rd_vld ? ram_rdata : '0;
    assign down    = last_row ? r_first : rd_mask;

    always_comb begin
        cell_wr        = rd_mask;
        cell_wr[r_col] = r_value;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode inside {MODE_READ, MODE_WRITE}) && in_range) begin
                    rd_en   = 1'b1;
                    rd_addr = i_row;
                end else if (accept && i_mode == MODE_ADV) begin
                    rd_en   = 1'b1;
                    rd_addr = rows_m1[ROW_W-1:0];
                end
            end
            ST_ADV_UP: begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(0);
            end
            ST_ADV_CUR: begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(1);
            end
            ST_ADV_ROW: begin
                rd_en   = 1'b1;
                rd_addr = idx_p2[ROW_W-1:0];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = cell_wr;
        case (r_state)
            ST_CELL: begin
                wr_en = (r_mode == MODE_WRITE);
            end
            ST_ADV_ROW: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[ROW_W-1:0];
                wr_data = next_row;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    tla_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    tla_row_eval u_eval (
        .i_up   (r_up),
        .i_cur  (r_cur),
        .i_down (down),
        .i_cols (cols_eff),
        .o_next (next_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
            r_row_cnt   <= CFG_W'(MAX_ROWS);
            r_col_cnt   <= CFG_W'(MAX_COLS);
        end else begin
            if (cfg_wr) begin
                if (paddr[APB_AW-1:2] == REG_ROWS) begin
                    r_row_cnt <= pwdata[CFG_W-1:0];
                end else begin
                    r_col_cnt <= pwdata[CFG_W-1:0];
                end
            end

            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_mode;
                        r_row      <= i_row;
                        r_col      <= i_col;
                        r_value    <= i_value;
                        r_res_cell <= 1'b0;
                        r_res_oor  <= (i_mode inside {MODE_READ, MODE_WRITE}) && !in_range;
                        case (i_mode)
                            MODE_READ, MODE_WRITE: begin
                                if (in_range) begin
                                    r_state <= ST_CELL;
                                end else begin
                                    r_state <= ST_FIN;
                                end
                            end
                            MODE_ADV: begin
                                r_state <= ST_ADV_UP;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_CELL: begin
                    if (r_mode == MODE_READ) begin
                        r_res_cell <= rd_mask[r_col];
                    end
                    r_state <= ST_FIN;
                end
                ST_ADV_UP: begin
                    r_up    <= rd_mask;
                    r_state <= ST_ADV_CUR;
                end
                ST_ADV_CUR: begin
                    r_cur   <= rd_mask;
                    r_first <= rd_mask;
                    r_idx   <= '0;
                    r_state <= ST_ADV_ROW;
                end
                ST_ADV_ROW: begin
                    r_up  <= r_cur;
                    r_cur <= down;
                    r_idx <= idx_p1;
                    if (last_row) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_cell  <= r_res_cell;
                        r_out_oor   <= r_res_oor;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_res     = r_out_cell;
    assign o_out_of_range = r_out_oor;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_COLS) ? APB_DW'(r_col_cnt)
                                                    : APB_DW'(r_row_cnt);
endmodule

// ===== hw/rtl/tla_checker.sv =====
// Port-level checks for the toroidal life automaton core, bound to the top level.
// Depends on toroidal_life_automaton_core ports only.
module tla_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_cell_res,
    input logic o_out_of_range,
    input logic pready
);
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

    a_res_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_cell_res && o_out_of_range))
        else $error("cell result set on an out-of-range beat");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cell_res) && $stable(o_out_of_range)))
        else $error("stalled result beat changed");
endmodule

bind toroidal_life_automaton_core tla_checker u_tla_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for toroidal_life_automaton_core: drives read, write and
// advance beats with random bursts and output stalls, and checks each result against a
// grid predictor kept in a small scoreboard class. Depends on tla_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tla_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 43;
    localparam logic [CFG_W-1:0] PHASE_ROWS [PHASES] =
        '{8'd5, 8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd7, 8'd128, 8'd12, 8'd4};
    localparam logic [CFG_W-1:0] PHASE_COLS [PHASES] =
        '{8'd6, 8'd255, 8'd1, 8'd2, 8'd3, 8'd0, 8'd128, 8'd9, 8'd12, 8'd4};

    typedef struct packed {
        logic cell_bit;
        logic oor;
    } life_res_t;

    class life_scoreboard;
        logic [MAX_COLS-1:0] grid [MAX_ROWS];
        logic [CFG_W-1:0]    rows_reg;
        logic [CFG_W-1:0]    cols_reg;
        life_res_t           want_q [$];
        int                  errors;
        int                  beats;

        function new();
            foreach (grid[r]) grid[r] = '0;
            rows_reg = 8'd128;
            cols_reg = 8'd128;
            errors = 0;
            beats = 0;
        endfunction

        function int clamp_size(logic [CFG_W-1:0] v, int lim);
            if (v == '0) return 1;
            if (int'(v) > lim) return lim;
            return int'(v);
        endfunction

        function int active_rows();
            return clamp_size(rows_reg, MAX_ROWS);
        endfunction

        function int active_cols();
            return clamp_size(cols_reg, MAX_COLS);
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void set_size(logic [REG_IW-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_ROWS) rows_reg = v;
            else if (idx == REG_COLS) cols_reg = v;
        endfunction

        // every neighbor offset counts, even when it wraps onto the same cell
        function void next_generation();
            logic [MAX_COLS-1:0] old [MAX_ROWS];
            int nr, nc, nb;
            nr = active_rows();
            nc = active_cols();
            old = grid;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    nb = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                nb += int'(old[(r + nr + dr) % nr][(c + nc + dc) % nc]);
                            end
                        end
                    end
                    grid[r][c] = old[r][c] ? (nb == 2 || nb == 3) : (nb == 3);
                end
            end
        endfunction

        function void note_item(logic [1:0] mode, logic [ROW_W-1:0] row,
                                logic [COL_W-1:0] col, logic value);
            life_res_t want;
            bit        outside;
            want = '0;
            outside = (int'(row) >= active_rows()) || (int'(col) >= active_cols());
            case (mode)
                MODE_READ: begin
                    if (outside) want.oor = 1'b1;
                    else want.cell_bit = grid[row][col];
                end
                MODE_WRITE: begin
                    if (outside) want.oor = 1'b1;
                    else grid[row][col] = value;
                end
                MODE_ADV: begin
                    next_generation();
                end
                default: begin
                end
            endcase
            want_q.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] beat %0d: %s", $time, beats, msg);
            errors++;
        endtask

        task check_result(logic cell_got, logic oor);
            life_res_t want;
            beats++;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected result cell=%0b oor=%0b", cell_got, oor));
                return;
            end
            want = want_q.pop_front();
            if (cell_got !== want.cell_bit) begin
                report($sformatf("cell_res %0b, want %0b", cell_got, want.cell_bit));
            end
            if (oor !== want.oor) begin
                report($sformatf("out_of_range %0b, want %0b", oor, want.oor));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_mode;
    logic [ROW_W-1:0]    i_row;
    logic [COL_W-1:0]    i_col;
    logic                i_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_cell_res;
    logic                o_out_of_range;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    life_scoreboard sb = new();
    int             burst_left = 0;
    int             cycle_cnt = 0;

    toroidal_life_automaton_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_res    (o_cell_res),
        .o_out_of_range(o_out_of_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_cell_res, o_out_of_range);
        end
    end

    // receiver: changes its stall style after each stretch of random length
    initial begin
        int style;
        i_out_ready = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(posedge i_clk);
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic value);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(mode, row, col, value);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IW-1:0] idx, input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_size(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
        wait_drained();
        apb_write(REG_ROWS, r);
        apb_write(REG_COLS, c);
    endtask

    task automatic run_phase(input int n_items, input bit hold_off);
        int               nr, nc, fill, pick;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        nr = sb.active_rows();
        nc = sb.active_cols();
        fill = n_items / 3;
        for (int k = 0; k < n_items; k++) begin
            row  = ROW_W'($urandom_range(0, nr - 1));
            col  = COL_W'($urandom_range(0, nc - 1));
            pick = (k < fill) ? 60 : $urandom_range(0, 99);
            if (hold_off && k == n_items / 2) wait_drained();
            if (pick < 15) begin
                send_item(MODE_ADV, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
            end else if (pick < 50) begin
                send_item(MODE_READ, row, col, 1'($urandom));
            end else if (pick < 75) begin
                send_item(MODE_WRITE, row, col, ($urandom_range(0, 99) < 45));
            end else if (pick < 88) begin
                if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1) == 0)) begin
                    row = ROW_W'($urandom_range(nr, MAX_ROWS - 1));
                    col = COL_W'($urandom);
                end else if (nc < MAX_COLS) begin
                    row = ROW_W'($urandom);
                    col = COL_W'($urandom_range(nc, MAX_COLS - 1));
                end
                send_item($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, row, col,
                          1'($urandom));
            end else begin
                send_item(2'($urandom), ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = MODE_READ;
        i_row      = '0;
        i_col      = '0;
        i_value    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full size after reset: corners, a blinker across the row wrap, spare mode
        send_item(MODE_READ, 7'd0, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd127, 7'd127, 1'b1);
        send_item(MODE_WRITE, 7'd127, 7'd127, 1'b1);
        send_item(MODE_WRITE, 7'd0, 7'd127, 1'b1);
        send_item(MODE_WRITE, 7'd1, 7'd127, 1'b1);
        send_item(MODE_READ, 7'd127, 7'd127, 1'b0);
        send_item(MODE_SPARE, 7'd127, 7'd127, 1'b1);
        send_item(MODE_ADV, 7'd0, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd0, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd0, 7'd126, 1'b0);
        send_item(MODE_READ, 7'd127, 7'd127, 1'b0);
        send_item(MODE_WRITE, 7'd5, 7'd5, 1'b0);

        // zero rows act as one, oversize columns clamp
        set_grid_size(8'd0, 8'd255);
        send_item(MODE_WRITE, 7'd0, 7'd10, 1'b1);
        send_item(MODE_WRITE, 7'd0, 7'd11, 1'b1);
        send_item(MODE_WRITE, 7'd0, 7'd12, 1'b1);
        send_item(MODE_READ, 7'd1, 7'd0, 1'b0);
        send_item(MODE_WRITE, 7'd1, 7'd0, 1'b1);
        send_item(MODE_ADV, 7'd0, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd0, 7'd11, 1'b0);

        // two rows by one column: wrapped neighbors count more than once
        set_grid_size(8'd2, 8'd1);
        send_item(MODE_WRITE, 7'd1, 7'd0, 1'b1);
        send_item(MODE_WRITE, 7'd0, 7'd5, 1'b1);
        send_item(MODE_ADV, 7'd0, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd1, 7'd0, 1'b0);
        send_item(MODE_READ, 7'd0, 7'd0, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            set_grid_size(PHASE_ROWS[p], PHASE_COLS[p]);
            run_phase(PHASE_ITEMS, (p == 4));
        end

        wait_drained();
        repeat (MAX_ROWS + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
